// ===== rtl/wbs_pkg.sv =====
// Shared types and constants for the word break segmenter.
// Holds the command codes, the word structs of both channels and the cell control struct.
// Depends on nothing; every other file of the block uses it.
package wbs_pkg;

	// Default capacity of the dictionary.
	localparam int MAX_WORDS_DEF    = 64;
	localparam int MAX_WORD_LEN_DEF = 32;

	// Command codes of a request word.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_DICT  = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;

	// One request word.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] character;
		logic       word_end;
		logic       text_start;
	} req_t;

	// One response word.
	typedef struct packed {
		logic can_split;
		logic dict_overflow;
	} rsp_t;

	// Controls shared by every cell of the chain.
	typedef struct packed {
		logic build_shift;
		logic text_shift;
		logic split_start;
		logic split_shift;
	} cell_ctl_t;

endpackage

// ===== rtl/word_break_segmenter.sv =====
// Word break segmenter.
// Request channel (req_valid, req_stall, req): each word carries a command. A clear word
// empties the dictionary, the text history and the overflow flag. A dictionary word shifts
// one character into the word being built; word_end commits it as a row of the dictionary.
// A text word shifts one character into the text window and yields one response word.
// Response channel (rsp_valid, rsp_stall, rsp): can_split tells whether the text through
// that character splits into dictionary words; dict_overflow is the sticky capacity flag.
// Clear and dictionary words do not stall the request channel. A text word passes through
// a scan, in which the dictionary memory delivers one stored word per cycle to the chain
// of window cells for comparison, and a finish step, which loads the response register.
// Only one text word is in work at a time; req_stall is high while it is, so a new text
// word is taken only after the last one's response has been loaded.
// A finished response waits in the output register while rsp_stall is high; meanwhile new
// request words are still accepted, and a following text word holds at its end until the
// register is free. Reset empties the dictionary and history, like a clear word.
// Dictionary characters beyond capacity are dropped and set the overflow flag.
module word_break_segmenter #(
	parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
	parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  wbs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output wbs_pkg::rsp_t rsp
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int WCW   = $clog2(MAX_WORDS + 1);
	localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int ROW_W = MAX_WORD_LEN * 8;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [WCW-1:0]     word_count_q;
	logic [LEN_W-1:0]   build_len_q;
	logic               too_long_q;
	logic               overflow_q;
	logic [LEN_W-1:0]   chars_seen_q;
	logic [WCW-1:0]     scan_idx_q;
	logic               rd_vld_s1;
	logic               hit_q;
	logic               rsp_valid_q;
	wbs_pkg::rsp_t      rsp_q;

	logic               req_acc;
	logic               clr_acc;
	logic               dict_acc;
	logic               text_acc;
	logic               dict_full;
	logic               word_long;
	logic               dict_store;
	logic [LEN_W-1:0]   new_len;
	logic               too_long_nx;
	logic               commit;
	logic [LEN_W-1:0]   seen_base;
	logic               rd_en;
	logic               scan_done;
	logic               fin_fire;
	logic               match;
	wbs_pkg::cell_ctl_t ctl;

	logic [7:0]             text_link  [MAX_WORD_LEN+1];
	logic [7:0]             build_link [MAX_WORD_LEN+1];
	logic                   split_link [MAX_WORD_LEN+1];
	logic [MAX_WORD_LEN-1:0] ok_vec;
	logic [MAX_WORD_LEN-1:0] sel_vec;
	logic [ROW_W-1:0]       wr_row;
	logic [ROW_W-1:0]       rd_row_s1;
	logic [LEN_W-1:0]       rd_len_s1;

	// Request decode; words are taken only while no text word is in work.
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		clr_acc  = 1'b0;
		dict_acc = 1'b0;
		text_acc = 1'b0;
		unique case (req.command)
			wbs_pkg::CMD_CLEAR: clr_acc  = req_acc;
			wbs_pkg::CMD_DICT:  dict_acc = req_acc;
			wbs_pkg::CMD_TEXT:  text_acc = req_acc;
			default: begin
			end
		endcase
	end

	// Dictionary loading: capacity checks and word commit.
	assign dict_full   = (word_count_q >= WCW'(MAX_WORDS));
	assign word_long   = (build_len_q >= LEN_W'(MAX_WORD_LEN));
	assign dict_store  = dict_acc && !dict_full && !word_long;
	assign new_len     = dict_store ? LEN_W'(build_len_q + 1'b1) : build_len_q;
	assign too_long_nx = too_long_q || (dict_acc && !dict_full && word_long);
	assign commit      = dict_acc && req.word_end && !dict_full && !too_long_nx &&
	                     (new_len != '0);

	// A new string restarts the count of characters seen.
	assign seen_base = req.text_start ? '0 : chars_seen_q;

	// Scan sequencing: one dictionary row read per cycle.
	assign rd_en     = (state_q == ST_SCAN) && (scan_idx_q < word_count_q);
	assign scan_done = (state_q == ST_SCAN) && !rd_en && !rd_vld_s1;
	assign fin_fire  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// Controls shared by the cell chain.
	always_comb begin
		ctl.build_shift = dict_store;
		ctl.text_shift  = text_acc;
		ctl.split_start = clr_acc || (text_acc && req.text_start);
		ctl.split_shift = fin_fire;
	end

	// Chain inputs at the head of the row.
	assign text_link[0]  = req.character;
	assign build_link[0] = req.character;
	assign split_link[0] = hit_q;

	// The row of window cells.
	for (genvar d = 0; d < MAX_WORD_LEN; d++) begin : g_cell
		assign wr_row[d*8 +: 8] = build_link[d];

		wbs_cell #(
			.MAX_WORD_LEN (MAX_WORD_LEN),
			.INDEX        (d)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.text_in   (text_link[d]),
			.text_out  (text_link[d+1]),
			.split_in  (split_link[d]),
			.split_out (split_link[d+1]),
			.build_in  (build_link[d]),
			.build_out (build_link[d+1]),
			.dict_char (rd_row_s1[d*8 +: 8]),
			.word_len  (rd_len_s1),
			.match_ok  (ok_vec[d]),
			.split_sel (sel_vec[d])
		);
	end

	// Dictionary memory.
	wbs_dict #(
		.MAX_WORDS    (MAX_WORDS),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_dict (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (word_count_q[AW-1:0]),
		.wr_row  (wr_row),
		.wr_len  (new_len),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[AW-1:0]),
		.rd_row  (rd_row_s1),
		.rd_len  (rd_len_s1)
	);

	// A word matches if it fits the text seen, all characters agree and its prefix splits.
	assign match = rd_vld_s1 && (&ok_vec) && (|sel_vec) && (rd_len_s1 <= chars_seen_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			build_len_q  <= '0;
			too_long_q   <= 1'b0;
			overflow_q   <= 1'b0;
			chars_seen_q <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;

			// Dictionary state.
			if (clr_acc) begin
				word_count_q <= '0;
				build_len_q  <= '0;
				too_long_q   <= 1'b0;
				overflow_q   <= 1'b0;
				chars_seen_q <= '0;
			end else if (dict_acc) begin
				if (dict_full || word_long) begin
					overflow_q <= 1'b1;
				end
				if (commit) begin
					word_count_q <= WCW'(word_count_q + 1'b1);
				end
				if (req.word_end) begin
					build_len_q <= '0;
					too_long_q  <= 1'b0;
				end else begin
					build_len_q <= new_len;
					too_long_q  <= too_long_nx;
				end
			end else if (text_acc) begin
				if (seen_base < LEN_W'(MAX_WORD_LEN)) begin
					chars_seen_q <= LEN_W'(seen_base + 1'b1);
				end else begin
					chars_seen_q <= seen_base;
				end
			end

			// Scan index and accumulated hit.
			if (text_acc) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_idx_q <= WCW'(scan_idx_q + 1'b1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end

			// Sequencer.
			unique case (state_q)
				ST_IDLE: begin
					if (text_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Output register handshake.
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			rsp_q.can_split     <= hit_q;
			rsp_q.dict_overflow <= overflow_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/wbs_cell.sv =====
// One cell of the window chain: a text character, a split flag and a character of the
// word being loaded, each handed to the next cell on a shift. Compares its text character
// against one character of a stored word. Depends on wbs_pkg.
module wbs_cell #(
	parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF,
	parameter int INDEX        = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wbs_pkg::cell_ctl_t                ctl,
	input  logic [7:0]                        text_in,
	output logic [7:0]                        text_out,
	input  logic                              split_in,
	output logic                              split_out,
	input  logic [7:0]                        build_in,
	output logic [7:0]                        build_out,
	input  logic [7:0]                        dict_char,
	input  logic [$clog2(MAX_WORD_LEN+1)-1:0] word_len,
	output logic                              match_ok,
	output logic                              split_sel
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

	logic [7:0] text_q;
	logic [7:0] build_q;
	logic       split_q;

	// Character registers shift only when their window moves.
	always_ff @(posedge clk) begin
		if (ctl.text_shift) begin
			text_q <= text_in;
		end
		if (ctl.build_shift) begin
			build_q <= build_in;
		end
	end

	// The split flag of the first cell marks the empty prefix at the start of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= (INDEX == 0);
		end else if (ctl.split_start) begin
			split_q <= (INDEX == 0);
		end else if (ctl.split_shift) begin
			split_q <= split_in;
		end
	end

	assign text_out  = text_q;
	assign build_out = build_q;
	assign split_out = split_q;

	// A position beyond the word's length always agrees.
	assign match_ok  = (LEN_W'(INDEX) >= word_len) || (dict_char == text_q);
	// The prefix just before the word must be splittable.
	assign split_sel = split_q && (word_len == LEN_W'(INDEX + 1));

endmodule

// ===== rtl/wbs_dict.sv =====
// Dictionary store: one row per word, characters aligned with the text window, plus length.
// Written one whole word per cycle, read one word per cycle with registered output.
// Depends on wbs_pkg for parameter defaults.
module wbs_dict #(
	parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
	parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
	input  logic                                              clk,
	input  logic                                              wr_en,
	input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] wr_addr,
	input  logic [MAX_WORD_LEN*8-1:0]                         wr_row,
	input  logic [$clog2(MAX_WORD_LEN+1)-1:0]                 wr_len,
	input  logic                                              rd_en,
	input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr,
	output logic [MAX_WORD_LEN*8-1:0]                         rd_row,
	output logic [$clog2(MAX_WORD_LEN+1)-1:0]                 rd_len
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int ROW_W = MAX_WORD_LEN * 8;

	logic [ROW_W-1:0] row_mem [MAX_WORDS];
	logic [LEN_W-1:0] len_mem [MAX_WORDS];

	// Word write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr] <= wr_row;
			len_mem[wr_addr] <= wr_len;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= row_mem[rd_addr];
			rd_len <= len_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/wbs_checker.sv =====
// Port-level checks for the word break segmenter, bound to the top level.
// Depends on wbs_pkg and on the port list of word_break_segmenter.
module wbs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input wbs_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input wbs_pkg::rsp_t rsp
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// An accepted text word keeps the request side stalled while it is in work.
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.command == wbs_pkg::CMD_TEXT) |=> req_stall)
		else $error("request accepted during text word work");

	// A new response only appears at the end of text word work.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without work in progress");

	// Clear and dictionary words never produce a response.
	a_no_dict_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.command != wbs_pkg::CMD_TEXT) && !rsp_valid
		|=> !rsp_valid)
		else $error("response produced by a non-text word");

endmodule

bind word_break_segmenter wbs_checker u_wbs_checker (.*);
